/* hw/rtl/erm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants of the echo range median filter
// Field widths, register indexes and the fixed-point constants for the
// conversion from echo width to distance.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int unsigned PULSE_W = 16;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_FIELDS = 3;

  // w * 343 stays below 2**25 for every 16-bit width, also after rounding.
  localparam int unsigned PROD_W    = 25;
  localparam int unsigned SOUND_NUM = 343;
  localparam int unsigned SOUND_DEN = 20000;
  localparam int unsigned HALF_DEN  = SOUND_DEN / 2;

  // floor(x / 20000) = floor((x >> 5) / 625). The quotient by 625 is a
  // multiply by ceil(2**30 / 625) followed by a shift, exact for 20-bit
  // operands.
  localparam int unsigned DEN_SHIFT   = 5;
  localparam int unsigned QUOT_IN_W   = PROD_W - DEN_SHIFT;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_625 = 21'd1717987;
  localparam int unsigned QUOT_W      = 11;

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd58;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd23200;
  localparam logic [DIST_W-1:0]  MIN_DIST_RST  = 10'd2;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 10'd400;
  localparam logic [DIST_W-1:0]  WINDOW_RST    = 10'd100;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_MIN_DIST  = 2'd2,
    REG_MAX_DIST  = 2'd3
  } cfg_reg_e;

  // What one attempt lane reports to the merge stage.
  typedef struct packed {
    logic   ok;
    pulse_t width;
  } lane_res_t;

endpackage

/* hw/rtl/erm_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_in_if: request channel carrying three echo widths
// Valid/ready handshake; a request moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface erm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] echo_first_us;
  logic [15:0] echo_second_us;
  logic [15:0] echo_third_us;

  modport source (
    output valid, echo_first_us, echo_second_us, echo_third_us,
    input  ready
  );
  modport sink (
    input  valid, echo_first_us, echo_second_us, echo_third_us,
    output ready
  );
endinterface

/* hw/rtl/erm_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_out_if: result channel carrying the filtered distance
// Valid/ready handshake; a result moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface erm_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] range_cm;
  logic       fresh;
  logic [1:0] valid_count;

  modport source (
    output valid, range_cm, fresh, valid_count,
    input  ready
  );
  modport sink (
    input  valid, range_cm, fresh, valid_count,
    output ready
  );
endinterface

/* hw/rtl/erm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_lane: one attempt lane
// Checks one echo width against the configured pulse window.
// ----------------------------------------------------------------------------
module erm_lane (
  input  erm_pkg::pulse_t    width_i,
  input  erm_pkg::pulse_t    min_pulse_i,
  input  erm_pkg::pulse_t    max_pulse_i,
  output erm_pkg::lane_res_t res_o
);
  import erm_pkg::*;

  // A zero width means no echo, even when the lower bound is zero.
  assign res_o.ok    = (width_i != '0) && (width_i >= min_pulse_i) &&
                       (width_i <= max_pulse_i);
  assign res_o.width = width_i;

endmodule

/* hw/rtl/erm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_merge: merge of the attempt lanes
// Counts the valid lanes and picks the upper median of their widths by rank.
// ----------------------------------------------------------------------------
module erm_merge #(
  parameter int unsigned ATTEMPTS = 3,
  localparam int unsigned CW = $clog2(ATTEMPTS + 1)
) (
  input  erm_pkg::lane_res_t res_i [ATTEMPTS],
  output erm_pkg::pulse_t    width_o,
  output logic [CW-1:0]      count_o
);
  import erm_pkg::*;

  logic [CW-1:0] rank [ATTEMPTS];
  logic [CW-1:0] cnt;
  pulse_t        sel;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < ATTEMPTS; i++) begin
      cnt = cnt + CW'(res_i[i].ok);
    end
  end

  // Ties go to the lower lane, so the ranks of the valid lanes are distinct.
  always_comb begin
    for (int i = 0; i < ATTEMPTS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < ATTEMPTS; j++) begin
        if (j != i && res_i[j].ok &&
            ((res_i[j].width < res_i[i].width) ||
             (res_i[j].width == res_i[i].width && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < ATTEMPTS; i++) begin
      if (res_i[i].ok && rank[i] == (cnt >> 1)) begin
        sel = sel | res_i[i].width;
      end
    end
  end

  assign width_o = sel;
  assign count_o = cnt;

endmodule

/* hw/rtl/erm_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_window: sliding median window
// Holds the last distances in a ring and gives the median of the window
// as it stands after the pending write.
// ----------------------------------------------------------------------------
module erm_window #(
  parameter int unsigned WINDOW_SIZE = 5,
  localparam int unsigned PW = $clog2(WINDOW_SIZE)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  erm_pkg::dist_t val_i,
  output erm_pkg::dist_t med_o
);
  import erm_pkg::*;

  dist_t         win_q [WINDOW_SIZE];
  dist_t         win_d [WINDOW_SIZE];
  logic [PW-1:0] ptr_q, ptr_d;
  logic [PW-1:0] rank [WINDOW_SIZE];
  dist_t         med;

  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      win_d[i] = (ptr_q == PW'(i)) ? val_i : win_q[i];
    end
  end

  assign ptr_d = (ptr_q == PW'(WINDOW_SIZE - 1)) ? '0 : ptr_q + 1'b1;

  // Each entry counts the entries that sort before it; the one with rank
  // WINDOW_SIZE/2 is the median.
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_SIZE; j++) begin
        if (j != i && ((win_d[j] < win_d[i]) ||
                       (win_d[j] == win_d[i] && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (rank[i] == PW'(WINDOW_SIZE / 2)) begin
        med = med | win_d[i];
      end
    end
  end

  assign med_o = med;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_q[i] <= WINDOW_RST;
      end
    end else if (upd_i) begin
      ptr_q <= ptr_d;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

/* hw/rtl/echo_range_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_median_filter: echo ranging with a sliding median
// Validates three echo widths in parallel lanes, takes their upper median,
// converts it to centimeters and filters it through a median window.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    echo_first_us, echo_second_us, echo_third_us
//   out_o    out  valid/ready    range_cm, fresh, valid_count
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One request per cycle is accepted while the output does not stall; a result
// passes the registered stages for lanes and merge, scale multiply, reciprocal
// divide and window. The window update and its median close in the same cycle.
// Reset restores the register defaults, fills the window with 100 and
// clears the held distance. A stalled output lets the stages behind it fill
// before in_i.ready drops.
// ----------------------------------------------------------------------------
module echo_range_median_filter #(
  parameter int unsigned WINDOW_SIZE = 5,
  parameter int unsigned ATTEMPTS    = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  erm_in_if.sink                              in_i,
  erm_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [erm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import erm_pkg::*;

  localparam int unsigned CW = $clog2(ATTEMPTS + 1);

  // Configuration, with the distance limits kept as product thresholds.
  pulse_t              min_pulse_q, max_pulse_q;
  dist_t               max_dist_q;
  logic [PROD_W-1:0]   thr_lo_q, thr_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pulse_q <= MIN_PULSE_RST;
      max_pulse_q <= MAX_PULSE_RST;
      max_dist_q  <= MAX_DIST_RST;
      thr_lo_q    <= PROD_W'(MIN_DIST_RST * SOUND_DEN);
      thr_hi_q    <= PROD_W'(MAX_DIST_RST * SOUND_DEN);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_PULSE: min_pulse_q <= cfg_wdata_i;
        REG_MAX_PULSE: max_pulse_q <= cfg_wdata_i;
        REG_MIN_DIST: begin
          thr_lo_q   <= PROD_W'(cfg_wdata_i[DIST_W-1:0] * SOUND_DEN);
        end
        REG_MAX_DIST: begin
          max_dist_q <= cfg_wdata_i[DIST_W-1:0];
          thr_hi_q   <= PROD_W'(cfg_wdata_i[DIST_W-1:0] * SOUND_DEN);
        end
        default: ;
      endcase
    end
  end

  // Attempt lanes; attempts past the third field see no echo.
  lane_res_t lane_res [ATTEMPTS];

  for (genvar g = 0; g < ATTEMPTS; g++) begin : g_lane
    pulse_t w;
    if (g == 0) begin : g_first
      assign w = in_i.echo_first_us;
    end else if (g == 1) begin : g_second
      assign w = in_i.echo_second_us;
    end else if (g == 2) begin : g_third
      assign w = in_i.echo_third_us;
    end else begin : g_none
      assign w = '0;
    end
    erm_lane u_lane (
      .width_i     (w),
      .min_pulse_i (min_pulse_q),
      .max_pulse_i (max_pulse_q),
      .res_o       (lane_res[g])
    );
  end

  pulse_t        mrg_width;
  logic [CW-1:0] mrg_count;

  erm_merge #(.ATTEMPTS(ATTEMPTS)) u_merge (
    .res_i   (lane_res),
    .width_o (mrg_width),
    .count_o (mrg_count)
  );

  // Pipeline control.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;
  logic in_acc, s1_adv, s2_adv, s3_adv;

  assign out_rdy = !out_v_q || out_o.ready;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;

  assign in_i.ready = s1_rdy;
  assign in_acc = in_i.valid && s1_rdy;
  assign s1_adv = s1_v_q && s2_rdy;
  assign s2_adv = s2_v_q && s3_rdy;
  assign s3_adv = s3_v_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_i.valid;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  // Stage payloads.
  pulse_t              s1_w_q;
  logic [CW-1:0]       s1_n_q, s2_n_q, s3_n_q;
  logic [PROD_W-1:0]   s2_p_q;
  dist_t               s3_dist_q;
  dist_t               out_dist_q;
  logic                out_fresh_q;
  logic [1:0]          out_cnt_q;

  logic [PROD_W-1:0]                 s2_p_d;
  logic [QUOT_IN_W-1:0]              quot_in;
  logic [QUOT_IN_W+RECIP_W-1:0]      quot_prod;
  logic [QUOT_W-1:0]                 quot;
  dist_t                             s3_dist_d;

  assign s2_p_d = PROD_W'(s1_w_q * SOUND_NUM);

  assign quot_in   = QUOT_IN_W'((s2_p_q + PROD_W'(HALF_DEN)) >> DEN_SHIFT);
  assign quot_prod = quot_in * RECIP_625;
  assign quot      = quot_prod[RECIP_SHIFT +: QUOT_W];

  // The lower limit is tested first, so with crossed limits a product below it gives zero.
  always_comb begin
    if (s2_p_q < thr_lo_q) begin
      s3_dist_d = '0;
    end else if (s2_p_q > thr_hi_q) begin
      s3_dist_d = max_dist_q;
    end else begin
      s3_dist_d = quot[DIST_W-1:0];
    end
  end

  // Window stage; with no valid attempt the held distance is repeated.
  logic  s3_fresh;
  logic  win_upd;
  dist_t win_med;
  dist_t last_q;

  assign s3_fresh = (s3_n_q != '0);
  assign win_upd  = s3_adv && s3_fresh;

  erm_window #(.WINDOW_SIZE(WINDOW_SIZE)) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (win_upd),
    .val_i  (s3_dist_q),
    .med_o  (win_med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (win_upd) begin
      last_q <= win_med;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_w_q <= mrg_width;
      s1_n_q <= mrg_count;
    end
    if (s1_adv) begin
      s2_p_q <= s2_p_d;
      s2_n_q <= s1_n_q;
    end
    if (s2_adv) begin
      s3_dist_q <= s3_dist_d;
      s3_n_q    <= s2_n_q;
    end
    if (s3_adv) begin
      out_dist_q  <= s3_fresh ? win_med : last_q;
      out_fresh_q <= s3_fresh;
      out_cnt_q   <= (s3_n_q > CW'(3)) ? 2'd3 : 2'(s3_n_q);
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.range_cm    = out_dist_q;
  assign out_o.fresh       = out_fresh_q;
  assign out_o.valid_count = out_cnt_q;

  // A result is marked fresh exactly when some attempt was valid.
  a_fresh_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.fresh == (out_o.valid_count != 2'd0)))
    else $error("fresh flag disagrees with valid count");

  // A request with no valid attempt repeats the held distance.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_adv && !s3_fresh) |=> (out_o.range_cm == $past(last_q)))
    else $error("held distance not repeated");

  // The held distance changes only through a window update.
  a_last_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_upd |=> $stable(last_q))
    else $error("held distance changed without a fresh request");

  // An accepted request always occupies the first stage next cycle.
  a_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_v_q)
    else $error("accepted request lost");

endmodule

/* tb/erm_range_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_range_checker: scoreboard for the echo range median filter
// Watches both channels and the register port. It keeps its own copy of the
// registers, the median window and the held distance. For every accepted
// request it works out the filtered reading and compares it field by field
// with the next result that leaves the block.
// ----------------------------------------------------------------------------
module erm_range_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  erm_in_if                              echo_mon,
  erm_out_if                             range_mon,
  input  logic                           cfg_we_i,
  input  logic [erm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             errors_o,
  output int                             pending_o
);
  import erm_pkg::*;

  localparam int unsigned WINDOW_DEPTH = 5;
  localparam int unsigned ATTEMPT_CNT  = 3;
  localparam logic [31:0] CM_NUM       = 32'd343;
  localparam logic [31:0] CM_DEN       = 32'd20000;
  localparam logic [31:0] CM_ROUND     = 32'd10000;
  localparam pulse_t      PULSE_LO_RST = 16'd58;
  localparam pulse_t      PULSE_HI_RST = 16'd23200;
  localparam dist_t       DIST_LO_RST  = 10'd2;
  localparam dist_t       DIST_HI_RST  = 10'd400;
  localparam dist_t       HISTORY_RST  = 10'd100;

  typedef struct packed {
    dist_t      distance;
    logic       fresh;
    logic [1:0] count;
  } reading_t;

  pulse_t      lo_pulse, hi_pulse;
  dist_t       lo_dist, hi_dist;
  dist_t       history [WINDOW_DEPTH];
  int unsigned slot;
  dist_t       held;
  reading_t    awaited_q [$];
  int          fails;

  function automatic dist_t width_to_dist(pulse_t w);
    logic [31:0] prod;
    prod = 32'(w) * CM_NUM;
    // The lower bound wins when the two limits are crossed.
    if (prod < 32'(lo_dist) * CM_DEN) return '0;
    if (prod > 32'(hi_dist) * CM_DEN) return hi_dist;
    return dist_t'((prod + CM_ROUND) / CM_DEN);
  endfunction

  function automatic reading_t filter_echoes(pulse_t first, pulse_t second, pulse_t third);
    pulse_t   inbox [ATTEMPT_CNT];
    pulse_t   heard [ATTEMPT_CNT];
    dist_t    ordered [WINDOW_DEPTH];
    pulse_t   tmp_w;
    dist_t    tmp_d;
    int       n;
    reading_t r;
    inbox[0] = first;
    inbox[1] = second;
    inbox[2] = third;
    n = 0;
    for (int i = 0; i < ATTEMPT_CNT; i++) begin
      if (inbox[i] != '0 && inbox[i] >= lo_pulse && inbox[i] <= hi_pulse) begin
        heard[n] = inbox[i];
        n++;
      end
    end
    r.count = 2'(n);
    if (n == 0) begin
      r.distance = held;
      r.fresh    = 1'b0;
      return r;
    end
    for (int i = 0; i < n - 1; i++) begin
      for (int j = 0; j < n - 1 - i; j++) begin
        if (heard[j] > heard[j+1]) begin
          tmp_w      = heard[j];
          heard[j]   = heard[j+1];
          heard[j+1] = tmp_w;
        end
      end
    end
    // Upper median: the larger of two, the middle of three.
    history[slot] = width_to_dist(heard[n/2]);
    slot = (slot + 1) % WINDOW_DEPTH;
    ordered = history;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      for (int j = 0; j < WINDOW_DEPTH - 1 - i; j++) begin
        if (ordered[j] > ordered[j+1]) begin
          tmp_d        = ordered[j];
          ordered[j]   = ordered[j+1];
          ordered[j+1] = tmp_d;
        end
      end
    end
    held       = ordered[WINDOW_DEPTH/2];
    r.distance = held;
    r.fresh    = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      lo_pulse = PULSE_LO_RST;
      hi_pulse = PULSE_HI_RST;
      lo_dist  = DIST_LO_RST;
      hi_dist  = DIST_HI_RST;
      for (int i = 0; i < WINDOW_DEPTH; i++) history[i] = HISTORY_RST;
      slot = 0;
      held = '0;
      awaited_q.delete();
      fails = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MIN_PULSE: lo_pulse = cfg_wdata_i;
          REG_MAX_PULSE: hi_pulse = cfg_wdata_i;
          REG_MIN_DIST:  lo_dist  = cfg_wdata_i[DIST_W-1:0];
          REG_MAX_DIST:  hi_dist  = cfg_wdata_i[DIST_W-1:0];
          default: ;
        endcase
      end
      if (echo_mon.valid && echo_mon.ready) begin
        awaited_q.push_back(filter_echoes(echo_mon.echo_first_us, echo_mon.echo_second_us,
                                          echo_mon.echo_third_us));
      end
      if (range_mon.valid && range_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unrequested result: expected none, got range %0d fresh %0d count %0d",
                   $time, range_mon.range_cm, range_mon.fresh, range_mon.valid_count);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (range_mon.range_cm !== want.distance) begin
            $display("%0t: range_cm expected %0d got %0d",
                     $time, want.distance, range_mon.range_cm);
            fails++;
          end
          if (range_mon.fresh !== want.fresh) begin
            $display("%0t: fresh expected %0d got %0d", $time, want.fresh, range_mon.fresh);
            fails++;
          end
          if (range_mon.valid_count !== want.count) begin
            $display("%0t: valid_count expected %0d got %0d",
                     $time, want.count, range_mon.valid_count);
            fails++;
          end
        end
      end
      errors_o  <= fails;
      pending_o <= awaited_q.size();
    end
  end

endmodule

/* tb/tb_echo_range_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_range_median_filter: regression bench for the echo range filter
// Drives echo width requests through several register settings: the reset
// defaults, the widest limits, an empty pulse window, crossed distance
// limits and random settings. Both channels stall at random, and once the
// result side holds off long enough to back up the input. The checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_echo_range_median_filter;
  import erm_pkg::*;

  localparam int PERIOD        = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int GAP_MAX       = 18;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    err_count;
  int                    waiting;
  int                    idle_cycles;
  bit                    gaps_on;
  bit                    stalls_on;
  bit                    hold_req;
  int unsigned           cur_min_p, cur_max_p, cur_min_d, cur_max_d;

  erm_in_if  echo_ch ();
  erm_out_if range_ch ();

  always #(PERIOD/2) clk_i = ~clk_i;

  echo_range_median_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (echo_ch),
    .out_o       (range_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  erm_range_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .echo_mon    (echo_ch),
    .range_mon   (range_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (err_count),
    .pending_o   (waiting)
  );

  task automatic send_echo(pulse_t first, pulse_t second, pulse_t third);
    echo_ch.valid          <= 1'b1;
    echo_ch.echo_first_us  <= first;
    echo_ch.echo_second_us <= second;
    echo_ch.echo_third_us  <= third;
    @(posedge clk_i);
    while (!echo_ch.ready) @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      echo_ch.valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
    end
  endtask

  // Mostly widths that pass the current window, plus edges of the window,
  // edges of the distance limits, zeros and raw noise.
  function automatic pulse_t pick_width();
    int unsigned roll;
    int          v;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 22) return pulse_t'($urandom);
    if (roll < 34) v = int'(roll[0] ? cur_min_p : cur_max_p) + int'($urandom_range(0, 4)) - 2;
    else if (roll < 44) v = int'(((roll[0] ? cur_min_d : cur_max_d) * 20000) / 343)
                            + int'($urandom_range(0, 4)) - 2;
    else return pulse_t'($urandom_range(cur_min_p, cur_max_p));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return pulse_t'(v);
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 6) send_echo('0, '0, '0);
      else send_echo(pick_width(), pick_width(), pick_width());
    end
  endtask

  // Lets every outstanding request come back before the registers change.
  task automatic settle();
    echo_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(int unsigned min_p, int unsigned max_p,
                                int unsigned min_d, int unsigned max_d);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MIN_PULSE;
    cfg_wdata <= CFG_DATA_W'(min_p);
    @(posedge clk_i);
    cfg_idx   <= REG_MAX_PULSE;
    cfg_wdata <= CFG_DATA_W'(max_p);
    @(posedge clk_i);
    cfg_idx   <= REG_MIN_DIST;
    cfg_wdata <= CFG_DATA_W'(min_d);
    @(posedge clk_i);
    cfg_idx   <= REG_MAX_DIST;
    cfg_wdata <= CFG_DATA_W'(max_d);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_min_p = min_p;
    cur_max_p = max_p;
    cur_min_d = min_d;
    cur_max_d = max_d;
  endtask

  // Result side: random stalls, and one long hold-off when asked for.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    range_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        range_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        range_ch.ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        range_ch.ready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
        range_ch.ready <= 1'b1;
      end else begin
        range_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (echo_ch.valid && echo_ch.ready) || (range_ch.valid && range_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = REG_MIN_PULSE;
    cfg_wdata              = '0;
    echo_ch.valid          = 1'b0;
    echo_ch.echo_first_us  = '0;
    echo_ch.echo_second_us = '0;
    echo_ch.echo_third_us  = '0;
    gaps_on                = 1'b1;
    stalls_on              = 1'b1;
    hold_req               = 1'b0;
    cur_min_p = 58;
    cur_max_p = 23200;
    cur_min_d = 2;
    cur_max_d = 400;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: nothing heard first, so the cleared held value shows.
    send_echo(16'd0, 16'd0, 16'd0);
    send_echo(16'd58, 16'd0, 16'd0);
    send_echo(16'd57, 16'd23201, 16'd65535);
    send_echo(16'd23200, 16'd23200, 16'd23200);
    send_echo(16'd116, 16'd117, 16'd0);
    send_echo(16'd117, 16'd116, 16'd5000);
    send_echo(16'd1, 16'd2, 16'd3);
    send_echo(16'd3000, 16'd1000, 16'd2000);
    send_echo(16'd2000, 16'd3000, 16'd1000);
    send_echo(16'd0, 16'd0, 16'd23200);
    send_echo(16'd0, 16'd58, 16'd0);
    send_echo(16'hAAAA, 16'h5555, 16'h1555);
    send_echo(16'd65535, 16'd65535, 16'd65535);
    send_echo(16'd11661, 16'd11662, 16'd0);
    // Fill the result path and back up the request side.
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_random(40);
    gaps_on  = 1'b1;
    send_random(150);
    settle();

    // Widest limits: a zero width still does not count.
    apply_settings(0, 65535, 0, 1023);
    send_echo(16'd0, 16'd0, 16'd1);
    send_echo(16'd65535, 16'd0, 16'd0);
    send_echo(16'd1, 16'd0, 16'd0);
    send_echo(16'd65535, 16'd65535, 16'd1);
    send_random(150);
    settle();

    // Empty pulse window: every request holds the last distance.
    apply_settings(65535, 0, 2, 400);
    send_echo(16'd65535, 16'd0, 16'd1);
    send_random(50);
    settle();

    // Crossed distance limits: the lower bound is tested first.
    apply_settings(1, 65535, 1023, 0);
    send_echo(16'd65535, 16'd60000, 16'd1);
    send_random(50);
    settle();
    apply_settings(58, 23200, 300, 200);
    send_random(60);
    settle();

    repeat (3) begin
      int unsigned lo;
      lo = $urandom_range(0, 3000);
      apply_settings(lo, $urandom_range(lo, 65535), $urandom_range(0, 60),
                     $urandom_range(50, 1023));
      send_random(100);
      settle();
    end

    // Closing stretch with no idling on either side.
    apply_settings(58, 23200, 2, 400);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_random(100);
    settle();

    if (err_count == 0 && waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/erm_pkg.sv
hw/rtl/erm_in_if.sv
hw/rtl/erm_out_if.sv
hw/rtl/erm_lane.sv
hw/rtl/erm_merge.sv
hw/rtl/erm_window.sv
hw/rtl/echo_range_median_filter.sv
tb/erm_range_checker.sv
tb/tb_echo_range_median_filter.sv
